@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the text overlay RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ design/tovl_pkg.sv @@
// ----------------------------------------------------------------------------
// tovl_pkg
// Types, constants, font table and helper functions for the text overlay.
// ----------------------------------------------------------------------------
`default_nettype none

package tovl_pkg;

    localparam int MAX_CHARS_DEF = 32;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 16;
    localparam int SCALE_W    = 3;
    localparam int LEN_W      = 6;
    localparam int DX_W       = 11;   // offset inside the text, below 32*6*7
    localparam int DY_W       = 6;    // row offset inside the text, below 7*7
    localparam int RECIP_W    = 17;
    localparam int RECIP_SH   = 16;
    localparam int U_W        = 8;    // font column index across the text
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int GLYPH_W    = 4;
    localparam int CHAR_IDX_W = 5;
    localparam int TEXT_BITS  = 256;
    localparam int DATA_W     = 64;
    localparam int PADDR_W    = 6;
    localparam int REG_IDX_W  = 3;

    // Division of a font column by six: u * 171 >> 10 is exact below 256.
    localparam int DIV6_MUL   = 171;
    localparam int DIV6_SH    = 10;
    localparam int DIV6_W     = 16;

    localparam logic [PIX_W-1:0] BOX_GREY  = 16'h2104;
    localparam logic [PIX_W-1:0] INK_WHITE = 16'hFFFF;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_DASH  = 8'h2D;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_K     = 8'h4B;
    localparam logic [7:0] ASCII_S     = 8'h53;
    localparam logic [7:0] ASCII_T     = 8'h54;

    localparam logic [GLYPH_W-1:0] GLYPH_COLON = 4'd10;
    localparam logic [GLYPH_W-1:0] GLYPH_DASH  = 4'd11;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 4'd12;
    localparam logic [GLYPH_W-1:0] GLYPH_K     = 4'd13;
    localparam logic [GLYPH_W-1:0] GLYPH_S     = 4'd14;
    localparam logic [GLYPH_W-1:0] GLYPH_T     = 4'd15;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_SCALE    = 3'd2,
        REG_LENGTH   = 3'd3,
        REG_TEXT_0   = 3'd4,
        REG_TEXT_1   = 3'd5,
        REG_TEXT_2   = 3'd6,
        REG_TEXT_3   = 3'd7
    } t_reg_idx;

    // Configuration and the values derived from it, held steady while pixels flow.
    typedef struct packed {
        logic [COORD_W-1:0]   origin_x;
        logic [COORD_W-1:0]   origin_y;
        logic [SCALE_W-1:0]   scale;
        logic [DX_W-1:0]      text_w;
        logic [DY_W-1:0]      text_h;
        logic [RECIP_W-1:0]   recip;
        logic [TEXT_BITS-1:0] text;
    } t_cfg;

    // Pixel after location: box flags, offset, coarse quotient and font row.
    typedef struct packed {
        logic             box;
        logic             in_text;
        logic [DX_W-1:0]  dx;
        logic [DX_W-1:0]  q;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
    } t_loc;

    localparam logic [4:0] FONT [16][7] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}
    };

    // floor(2^16 / scale); the quotient it gives is exact or one low.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] s);
        logic [RECIP_W-1:0] r;
        unique case (s)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21845;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13107;
            3'd6:    r = 17'd10922;
            3'd7:    r = 17'd9362;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] ch);
        logic [GLYPH_W-1:0] g;
        if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
            g = ch[GLYPH_W-1:0];
        end else begin
            unique case (ch)
                ASCII_COLON: g = GLYPH_COLON;
                ASCII_DASH:  g = GLYPH_DASH;
                ASCII_SPACE: g = GLYPH_SPACE;
                ASCII_K:     g = GLYPH_K;
                ASCII_S:     g = GLYPH_S;
                ASCII_T:     g = GLYPH_T;
                default:     g = GLYPH_SPACE;
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

@@ design/tovl_regs.sv @@
// ----------------------------------------------------------------------------
// tovl_regs
// APB register file for the overlay settings and the values derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module tovl_regs #(
    parameter int MAX_CHARS = tovl_pkg::MAX_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tovl_pkg::PADDR_W-1:0] paddr,
    input  logic [tovl_pkg::DATA_W-1:0]  pwdata,
    output logic [tovl_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tovl_pkg::t_cfg               o_cfg
);
    import tovl_pkg::*;

    logic [COORD_W-1:0] r_origin_x;
    logic [COORD_W-1:0] r_origin_y;
    logic [SCALE_W-1:0] r_scale;
    logic [LEN_W-1:0]   r_length;
    logic [DATA_W-1:0]  r_text_0;
    logic [DATA_W-1:0]  r_text_1;
    logic [DATA_W-1:0]  r_text_2;
    logic [DATA_W-1:0]  r_text_3;

    logic               w_wr;
    t_reg_idx           w_idx;
    logic [LEN_W-1:0]   w_len_sat;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1 -: REG_IDX_W]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= COORD_W'(8);
            r_origin_y <= COORD_W'(8);
            r_scale    <= SCALE_W'(2);
            r_length   <= '0;
            r_text_0   <= '0;
            r_text_1   <= '0;
            r_text_2   <= '0;
            r_text_3   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_X: r_origin_x <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y: r_origin_y <= pwdata[COORD_W-1:0];
                REG_SCALE:    r_scale    <= pwdata[SCALE_W-1:0];
                REG_LENGTH:   r_length   <= pwdata[LEN_W-1:0];
                REG_TEXT_0:   r_text_0   <= pwdata;
                REG_TEXT_1:   r_text_1   <= pwdata;
                REG_TEXT_2:   r_text_2   <= pwdata;
                REG_TEXT_3:   r_text_3   <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X: prdata = DATA_W'(r_origin_x);
            REG_ORIGIN_Y: prdata = DATA_W'(r_origin_y);
            REG_SCALE:    prdata = DATA_W'(r_scale);
            REG_LENGTH:   prdata = DATA_W'(r_length);
            REG_TEXT_0:   prdata = r_text_0;
            REG_TEXT_1:   prdata = r_text_1;
            REG_TEXT_2:   prdata = r_text_2;
            REG_TEXT_3:   prdata = r_text_3;
            default:      prdata = '0;
        endcase
    end

    // Text longer than the character store is cut to its size.
    assign w_len_sat = (r_length > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : r_length;

    always_comb begin
        o_cfg.origin_x = r_origin_x;
        o_cfg.origin_y = r_origin_y;
        o_cfg.scale    = r_scale;
        o_cfg.text_w   = DX_W'(w_len_sat) * DX_W'(r_scale) * DX_W'(6);
        o_cfg.text_h   = DY_W'(r_scale) * DY_W'(7);
        o_cfg.recip    = recip_of(r_scale);
        o_cfg.text     = {r_text_3, r_text_2, r_text_1, r_text_0};
    end

endmodule

`default_nettype wire

@@ design/tovl_locate.sv @@
// ----------------------------------------------------------------------------
// tovl_locate
// First two pipeline stages: box test, offsets, coarse column quotient, row.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tovl_locate (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tovl_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tovl_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [tovl_pkg::COORD_W-1:0] i_pixel_y,
    input  logic [tovl_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output tovl_pkg::t_loc               o_loc
);
    import tovl_pkg::*;

    typedef struct packed {
        logic             box;
        logic             in_text;
        logic [DX_W-1:0]  dx;
        logic [DY_W-1:0]  dy;
        logic [PIX_W-1:0] pixel;
    } t_s1;

    logic                    r_s1_v;
    t_s1                     r_s1;
    t_s1                     n_s1;
    logic                    r_s2_v;
    t_loc                    r_s2;
    t_loc                    n_s2;

    logic                    w_s1_ready;
    logic                    w_s2_ready;
    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic signed [COORD_W:0] w_s;
    logic signed [COORD_W:0] w_tw;
    logic signed [COORD_W:0] w_th;
    logic [DX_W+RECIP_W-1:0] w_prod;
    logic [ROW_W-1:0]        w_row;

    assign w_s2_ready = !r_s2_v || i_ready;
    assign w_s1_ready = !r_s1_v || w_s2_ready;
    assign o_ready    = w_s1_ready;

    // Stage 1: signed offsets from the text origin and the two rectangle tests.
    assign w_dx = $signed({1'b0, i_pixel_x}) - $signed({1'b0, i_cfg.origin_x});
    assign w_dy = $signed({1'b0, i_pixel_y}) - $signed({1'b0, i_cfg.origin_y});
    assign w_s  = $signed((COORD_W+1)'(i_cfg.scale));
    assign w_tw = $signed((COORD_W+1)'(i_cfg.text_w));
    assign w_th = $signed((COORD_W+1)'(i_cfg.text_h));

    always_comb begin
        n_s1.box     = (i_cfg.scale != '0) && (w_dx >= -w_s) && (w_dx < w_tw + w_s)
                       && (w_dy >= -w_s) && (w_dy < w_th + w_s);
        n_s1.in_text = (w_dx >= 0) && (w_dx < w_tw) && (w_dy >= 0) && (w_dy < w_th);
        n_s1.dx      = w_dx[DX_W-1:0];
        n_s1.dy      = w_dy[DY_W-1:0];
        n_s1.pixel   = i_pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    // Stage 2: dx / scale by reciprocal, and the font row by threshold count.
    assign w_prod = (DX_W+RECIP_W)'(r_s1.dx) * (DX_W+RECIP_W)'(i_cfg.recip);

    always_comb begin
        w_row = '0;
        for (int t = 1; t < 7; t++) begin
            if (r_s1.dy >= DY_W'(t) * DY_W'(i_cfg.scale)) begin
                w_row = w_row + ROW_W'(1);
            end
        end
    end

    always_comb begin
        n_s2.box     = r_s1.box;
        n_s2.in_text = r_s1.in_text;
        n_s2.dx      = r_s1.dx;
        n_s2.q       = w_prod[RECIP_SH +: DX_W];
        n_s2.row     = w_row;
        n_s2.pixel   = r_s1.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_v) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_v;
    assign o_loc   = r_s2;

    `ASSERT_NEVER(a_text_without_box, i_clk, i_rst_n, r_s1_v && r_s1.in_text && !r_s1.box, "text pixel outside box")
    `ASSERT_PROP(a_row_in_font, i_clk, i_rst_n, (r_s2_v && r_s2.in_text) |-> (r_s2.row < ROW_W'(7)), "font row out of range")

endmodule

`default_nettype wire

@@ design/tovl_render.sv @@
// ----------------------------------------------------------------------------
// tovl_render
// Last three pipeline stages: quotient fix-up, character and glyph select,
// font bit lookup and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tovl_render #(
    parameter int MAX_CHARS = tovl_pkg::MAX_CHARS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tovl_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  tovl_pkg::t_loc             i_loc,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tovl_pkg::PIX_W-1:0] o_pixel_out
);
    import tovl_pkg::*;

    typedef struct packed {
        logic             box;
        logic             in_text;
        logic [U_W-1:0]   u;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
    } t_s3;

    typedef struct packed {
        logic               box;
        logic               show;
        logic [GLYPH_W-1:0] glyph;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PIX_W-1:0]   pixel;
    } t_s4;

    logic                  r_s3_v;
    t_s3                   r_s3;
    t_s3                   n_s3;
    logic                  r_s4_v;
    t_s4                   r_s4;
    t_s4                   n_s4;
    logic                  r_out_v;
    logic [PIX_W-1:0]      r_pixel_out;
    logic [PIX_W-1:0]      n_pixel_out;

    logic                  w_out_ready;
    logic                  w_s4_ready;
    logic                  w_s3_ready;
    logic [DX_W-1:0]       w_qs;
    logic [DX_W-1:0]       w_rem;
    logic [DIV6_W-1:0]     w_k_prod;
    logic [CHAR_IDX_W-1:0] w_k;
    logic [COL_W-1:0]      w_col;
    logic [7:0]            w_char;
    logic [4:0]            w_row_bits;
    logic [2:0]            w_bit_idx;
    logic                  w_ink;

    assign w_out_ready = !r_out_v || !i_stall;
    assign w_s4_ready  = !r_s4_v || w_out_ready;
    assign w_s3_ready  = !r_s3_v || w_s4_ready;
    assign o_ready     = w_s3_ready;

    // Stage 3: the reciprocal quotient may be one low; one compare fixes it.
    assign w_qs  = i_loc.q * DX_W'(i_cfg.scale);
    assign w_rem = i_loc.dx - w_qs;

    always_comb begin
        n_s3.box     = i_loc.box;
        n_s3.in_text = i_loc.in_text;
        n_s3.u       = U_W'(i_loc.q + DX_W'(w_rem >= DX_W'(i_cfg.scale)));
        n_s3.row     = i_loc.row;
        n_s3.pixel   = i_loc.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_ready && i_valid) begin
            r_s3 <= n_s3;
        end
    end

    // Stage 4: the font column splits into character index and column in cell.
    assign w_k_prod = DIV6_W'(r_s3.u) * DIV6_W'(DIV6_MUL);
    assign w_k      = w_k_prod[DIV6_SH +: CHAR_IDX_W];
    assign w_col    = COL_W'(r_s3.u - U_W'(w_k) * U_W'(6));
    assign w_char   = i_cfg.text[{w_k, 3'b000} +: 8];

    always_comb begin
        n_s4.box   = r_s3.box;
        n_s4.show  = r_s3.in_text && (w_col < COL_W'(5))
                     && ((CHAR_IDX_W+1)'(w_k) < (CHAR_IDX_W+1)'(MAX_CHARS));
        n_s4.glyph = glyph_of(w_char);
        n_s4.col   = w_col;
        n_s4.row   = r_s3.row;
        n_s4.pixel = r_s3.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_s4_ready) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s4_ready && r_s3_v) begin
            r_s4 <= n_s4;
        end
    end

    // Stage 5: font lookup and color choice. Column zero is the leftmost bit.
    assign w_row_bits = FONT[r_s4.glyph][r_s4.row];
    assign w_bit_idx  = r_s4.show ? (3'd4 - r_s4.col) : 3'd0;
    assign w_ink      = r_s4.show && w_row_bits[w_bit_idx];

    always_comb begin
        if (!r_s4.box) begin
            n_pixel_out = r_s4.pixel;
        end else if (w_ink) begin
            n_pixel_out = INK_WHITE;
        end else begin
            n_pixel_out = BOX_GREY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_ready) begin
            r_out_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s4_v) begin
            r_pixel_out <= n_pixel_out;
        end
    end

    assign o_valid     = r_out_v;
    assign o_pixel_out = r_pixel_out;

    `ASSERT_PROP(a_quot_one_low, i_clk, i_rst_n, (i_valid && i_loc.in_text) |-> (w_rem < (DX_W'(i_cfg.scale) << 1)), "quotient estimate off by more than one")
    `ASSERT_PROP(a_col_in_text, i_clk, i_rst_n, (r_s3_v && r_s3.in_text) |-> (r_s3.u < U_W'(6 * MAX_CHARS)), "font column beyond text")

endmodule

`default_nettype wire

@@ design/text_overlay_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// text_overlay_pixel_generator
// Stamps a short text in a 5x7 font, on a grey box, over an RGB565 raster.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (i_valid, o_stall) with their column and
// row; one recolored pixel leaves on the output channel (o_valid, i_stall)
// for each one taken, in order. A transaction completes on a rising edge with
// valid high and stall low.
// Through five register stages (box test, reciprocal multiply, quotient
// fix-up, character select, font lookup) each pixel reaches the output
// register that drives o_valid. One pixel is taken every cycle while the
// output flows.
// When the receiver stalls, stages fill from the output back toward the input
// and o_stall rises only once the stage at the input holds a pixel; nothing is
// dropped or repeated.
// Settings must be written over the APB port only while no pixel is in flight;
// the block itself does not enforce this. Reset empties the pipeline and loads
// origin 8,8, scale 2 and an empty text.
`default_nettype none

module text_overlay_pixel_generator #(
    parameter int MAX_CHARS = tovl_pkg::MAX_CHARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [tovl_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [tovl_pkg::COORD_W-1:0] i_pixel_y,
    input  logic [tovl_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [tovl_pkg::PIX_W-1:0]   o_pixel_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tovl_pkg::PADDR_W-1:0] paddr,
    input  logic [tovl_pkg::DATA_W-1:0]  pwdata,
    output logic [tovl_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tovl_pkg::*;

    t_cfg w_cfg;
    logic w_in_ready;
    logic w_loc_valid;
    logic w_loc_ready;
    t_loc w_loc;

    tovl_regs #(
        .MAX_CHARS (MAX_CHARS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tovl_locate u_locate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_valid),
        .o_ready    (w_in_ready),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_pixel_in (i_pixel_in),
        .o_valid    (w_loc_valid),
        .i_ready    (w_loc_ready),
        .o_loc      (w_loc)
    );

    tovl_render #(
        .MAX_CHARS (MAX_CHARS)
    ) u_render (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_loc_valid),
        .o_ready     (w_loc_ready),
        .i_loc       (w_loc),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out)
    );

    assign o_stall = !w_in_ready;

endmodule

`default_nettype wire
